@@ sv/lcsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcsc_pkg: shared types and constants of the circle span clipper
// row limits, register indexes, queue entry type and classification codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lcsc_pkg;

  localparam int IDX_W      = 13;
  localparam int COORD_W    = 32;
  localparam int RLIM_W     = 31;
  localparam int RSQ_W      = 62;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 62;
  // wide enough for start + 4096 * step
  localparam int ACC_W      = 47;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [IDX_W-1:0] MAX_SAMPLES = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQUARED = 3'd4;

  // row classes
  localparam logic [1:0] KIND_FULL  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_SCAN  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic [1:0]                kind;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]         m;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic [RLIM_W-1:0]        rlim;
    logic [RSQ_W-1:0]         rsq;
  } cfg_t;

  function automatic logic [IDX_W-1:0] clamp_count(input logic [IDX_W-1:0] c);
    clamp_count = (c > MAX_SAMPLES) ? MAX_SAMPLES : c;
  endfunction

endpackage
`default_nettype wire

@@ sv/line_circle_span_clip.sv @@
// ----------------------------------------------------------------------------
// line_circle_span_clip: index span of a sample row inside a circle
// classifier, request queue and span scanner
// ----------------------------------------------------------------------------
//
//   channel  ports                                  handshake
//   input    in_start_x, in_start_y                 start & !busy
//   result   out_first_index, out_end_index         out_valid, one cycle
//   config   cfg_index, cfg_data                    cfg_we
//
// a row that passes the end point test, or is degenerate, is answered in the
// idle state; other rows pass the scan state, where the point test pipe
// squares one sample per cycle, then two post states. requests enter back to
// back while the queue has room; busy reflects queue fill. synchronous reset
// empties queue and scanner. results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module line_circle_span_clip #(
  parameter int QUEUE_DEPTH = lcsc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire signed [lcsc_pkg::COORD_W-1:0]  in_start_x,
  input  wire signed [lcsc_pkg::COORD_W-1:0]  in_start_y,
  output logic                                out_valid,
  output logic [lcsc_pkg::IDX_W-1:0]          out_first_index,
  output logic [lcsc_pkg::IDX_W-1:0]          out_end_index,
  input  wire                                 cfg_we,
  input  wire [lcsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [lcsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lcsc_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  cfg_t       cfg_r;
  logic       acc, push, pop, q_empty;
  entry_t     push_data, head;
  logic [CW-1:0] q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT:   cfg_r.m    <= cfg_data[IDX_W-1:0];
        REG_STEP_X:         cfg_r.sx   <= cfg_data[COORD_W-1:0];
        REG_STEP_Y:         cfg_r.sy   <= cfg_data[COORD_W-1:0];
        REG_RADIUS_LIMIT:   cfg_r.rlim <= cfg_data[RLIM_W-1:0];
        REG_RADIUS_SQUARED: cfg_r.rsq  <= cfg_data[RSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // one request may be in the classifier stage, count it as taken
  assign busy = ((CW+1)'(q_count) + (CW+1)'(push)) >= (CW+1)'(QUEUE_DEPTH);
  assign acc  = start && !busy;

  lcsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .x0        (in_start_x),
    .y0        (in_start_y),
    .cfg       (cfg_r),
    .push      (push),
    .push_data (push_data)
  );

  lcsc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  lcsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_first (out_first_index),
    .out_end   (out_end_index)
  );

endmodule
`default_nettype wire

@@ sv/lcsc_front.sv @@
// ----------------------------------------------------------------------------
// lcsc_front: row classifier
// end point products in one stage, quick test and class on the push
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lcsc_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              acc,
  input  wire signed [lcsc_pkg::COORD_W-1:0] x0,
  input  wire signed [lcsc_pkg::COORD_W-1:0] y0,
  input  wire lcsc_pkg::cfg_t              cfg,
  output logic                             push,
  output lcsc_pkg::entry_t                 push_data
);
  import lcsc_pkg::*;

  logic                       v1_r;
  logic signed [COORD_W-1:0]  x0_r, y0_r;
  logic signed [ACC_W-2:0]    px_r, py_r;
  logic [IDX_W-1:0]           m;
  logic signed [ACC_W-1:0]    xe, ye, xs, ys;
  logic [ACC_W-1:0]           axe, aye, axs, ays, lim;
  logic                       quick;

  assign m = clamp_count(cfg.m);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
    if (acc) begin
      x0_r <= x0;
      y0_r <= y0;
      px_r <= (ACC_W-1)'($signed({1'b0, m})) * (ACC_W-1)'(cfg.sx);
      py_r <= (ACC_W-1)'($signed({1'b0, m})) * (ACC_W-1)'(cfg.sy);
    end
  end

  always_comb begin
    xs  = ACC_W'(x0_r);
    ys  = ACC_W'(y0_r);
    xe  = xs + ACC_W'(px_r);
    ye  = ys + ACC_W'(py_r);
    axe = xe[ACC_W-1] ? ACC_W'(-xe) : ACC_W'(xe);
    aye = ye[ACC_W-1] ? ACC_W'(-ye) : ACC_W'(ye);
    axs = xs[ACC_W-1] ? ACC_W'(-xs) : ACC_W'(xs);
    ays = ys[ACC_W-1] ? ACC_W'(-ys) : ACC_W'(ys);
    lim = ACC_W'(cfg.rlim);
    quick = (axs <= lim) && (axe <= lim) && (ays <= lim) && (aye <= lim);
    push_data.x0 = x0_r;
    push_data.y0 = y0_r;
    priority if (quick) begin
      push_data.kind = KIND_FULL;
    end else if ((cfg.sx == '0 && cfg.sy == '0) || m == '0) begin
      push_data.kind = KIND_EMPTY;
    end else begin
      push_data.kind = KIND_SCAN;
    end
  end

  assign push = v1_r;

endmodule
`default_nettype wire

@@ sv/lcsc_fifo.sv @@
// ----------------------------------------------------------------------------
// lcsc_fifo: short request queue
// decouples the classifier from the span scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lcsc_fifo #(
  parameter int DEPTH = lcsc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  wire lcsc_pkg::entry_t   push_data,
  input  wire                     pop,
  output lcsc_pkg::entry_t        head,
  output logic                    empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import lcsc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH-1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= bump(wp_r);
      if (pop)  rp_r <= bump(rp_r);
      cnt_r <= CW'(cnt_r + CW'(push) - CW'(pop));
    end
    if (push) mem_r[wp_r] <= push_data;
  end

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule
`default_nettype wire

@@ sv/lcsc_back.sv @@
// ----------------------------------------------------------------------------
// lcsc_back: span scanner
// pipelined point test, one sample a cycle, then the tangent check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lcsc_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         q_empty,
  input  wire lcsc_pkg::entry_t       q_head,
  output logic                        q_pop,
  input  wire lcsc_pkg::cfg_t         cfg,
  output logic                        out_valid,
  output logic [lcsc_pkg::IDX_W-1:0]  out_first,
  output logic [lcsc_pkg::IDX_W-1:0]  out_end
);
  import lcsc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_POST1 = 2'd2;
  localparam logic [1:0] ST_POST2 = 2'd3;

  logic [1:0]               st_r, st_nxt;
  logic [IDX_W-1:0]         m;

  // generator
  logic                     g_act_r, g_act_nxt;
  logic signed [ACC_W-1:0]  g_x_r, g_y_r;
  logic [IDX_W-1:0]         g_i_r;
  logic                     g_last;
  logic [ACC_W-1:0]         ax, ay;

  // magnitude stage
  logic                     s1_v_r, s1_last_r, s1_ok_r;
  logic [IDX_W-1:0]         s1_i_r;
  logic [RLIM_W-1:0]        s1_ux_r, s1_uy_r;
  logic signed [COORD_W-1:0] s1_px_r, s1_py_r;

  // square stage
  logic                     s2_v_r, s2_last_r, s2_ok_r;
  logic [IDX_W-1:0]         s2_i_r;
  logic [RSQ_W-1:0]         s2_xx_r, s2_yy_r;
  logic signed [COORD_W-1:0] s2_px_r, s2_py_r;
  logic [RSQ_W:0]           s2_sum;
  logic                     s2_in;

  // span tracking
  logic                     found_r;
  logic [IDX_W-1:0]         first_r, end_r;
  logic [RSQ_W:0]           sumf_r;
  logic signed [COORD_W-1:0] pxf_r, pyf_r;
  logic signed [2*COORD_W-1:0] gx_r, gy_r;
  logic signed [2*COORD_W:0]   grad;
  logic                     tangent;

  logic                     ov_r;
  logic [IDX_W-1:0]         of_r, oe_r;

  assign m      = clamp_count(cfg.m);
  assign g_last = (g_i_r == IDX_W'(m - 1'b1));
  assign ax     = g_x_r[ACC_W-1] ? ACC_W'(-g_x_r) : ACC_W'(g_x_r);
  assign ay     = g_y_r[ACC_W-1] ? ACC_W'(-g_y_r) : ACC_W'(g_y_r);
  assign s2_sum = (RSQ_W+1)'(s2_xx_r) + (RSQ_W+1)'(s2_yy_r);
  assign s2_in  = s2_ok_r && (s2_sum <= (RSQ_W+1)'(cfg.rsq));
  assign grad   = (2*COORD_W+1)'(gx_r) + (2*COORD_W+1)'(gy_r);
  assign tangent = found_r && (end_r == IDX_W'(first_r + 1'b1)) &&
                   (sumf_r == (RSQ_W+1)'(cfg.rsq)) && (grad == '0);

  assign q_pop = (st_r == ST_IDLE) && !q_empty;

  always_comb begin
    st_nxt    = st_r;
    g_act_nxt = g_act_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty && q_head.kind == KIND_SCAN) begin
          st_nxt    = ST_SCAN;
          g_act_nxt = 1'b1;
        end
      end
      ST_SCAN: begin
        if (g_act_r && g_last) g_act_nxt = 1'b0;
        if (s2_v_r && s2_last_r) st_nxt = ST_POST1;
      end
      ST_POST1: st_nxt = ST_POST2;
      ST_POST2: st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      g_act_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      g_act_r <= g_act_nxt;
      s1_v_r  <= g_act_r;
      s2_v_r  <= s1_v_r;
      ov_r    <= (q_pop && q_head.kind != KIND_SCAN) || (st_r == ST_POST2);
    end

    // generator steps along the row
    if (st_r == ST_IDLE) begin
      g_x_r <= ACC_W'(q_head.x0);
      g_y_r <= ACC_W'(q_head.y0);
      g_i_r <= '0;
    end else if (g_act_r) begin
      g_x_r <= g_x_r + ACC_W'(cfg.sx);
      g_y_r <= g_y_r + ACC_W'(cfg.sy);
      g_i_r <= IDX_W'(g_i_r + 1'b1);
    end

    s1_last_r <= g_last;
    s1_i_r    <= g_i_r;
    s1_ok_r   <= (ax[ACC_W-1:RLIM_W] == '0) && (ay[ACC_W-1:RLIM_W] == '0);
    s1_ux_r   <= ax[RLIM_W-1:0];
    s1_uy_r   <= ay[RLIM_W-1:0];
    s1_px_r   <= g_x_r[COORD_W-1:0];
    s1_py_r   <= g_y_r[COORD_W-1:0];

    s2_last_r <= s1_last_r;
    s2_i_r    <= s1_i_r;
    s2_ok_r   <= s1_ok_r;
    s2_xx_r   <= RSQ_W'(s1_ux_r) * RSQ_W'(s1_ux_r);
    s2_yy_r   <= RSQ_W'(s1_uy_r) * RSQ_W'(s1_uy_r);
    s2_px_r   <= s1_px_r;
    s2_py_r   <= s1_py_r;

    // span update
    if (st_r == ST_IDLE) begin
      found_r <= 1'b0;
    end else if (s2_v_r && s2_in) begin
      found_r <= 1'b1;
      end_r   <= IDX_W'(s2_i_r + 1'b1);
      if (!found_r) begin
        first_r <= s2_i_r;
        sumf_r  <= s2_sum;
        pxf_r   <= s2_px_r;
        pyf_r   <= s2_py_r;
      end
    end

    if (st_r == ST_POST1) begin
      gx_r <= (2*COORD_W)'(cfg.sx) * (2*COORD_W)'(pxf_r);
      gy_r <= (2*COORD_W)'(cfg.sy) * (2*COORD_W)'(pyf_r);
    end

    // result register
    if (q_pop && q_head.kind == KIND_FULL) begin
      of_r <= '0;
      oe_r <= m;
    end else if (q_pop && q_head.kind != KIND_SCAN) begin
      of_r <= m;
      oe_r <= m;
    end else if (st_r == ST_POST2) begin
      if (!found_r || tangent) begin
        of_r <= m;
        oe_r <= m;
      end else begin
        of_r <= first_r;
        oe_r <= end_r;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_first = of_r;
  assign out_end   = oe_r;

endmodule
`default_nettype wire

@@ sv/lcsc_checker.sv @@
// ----------------------------------------------------------------------------
// lcsc_checker: port level checks of the span clipper
// result ordering and range, reset and busy behavior
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lcsc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire [12:0] out_first_index,
  input wire [12:0] out_end_index
);

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_first_index <= out_end_index)
    else $error("first index beyond end index");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_end_index <= 13'd4096)
    else $error("end index beyond row limit");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind line_circle_span_clip lcsc_checker u_lcsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_first_index (out_first_index),
  .out_end_index   (out_end_index)
);
`default_nettype wire

@@ tb/line_circle_span_clip_tb.sv @@
// ----------------------------------------------------------------------------
// line_circle_span_clip_tb: self-checking bench for the circle span clipper
// drives row start requests through the start/busy handshake, predicts each
// index span in a scoreboard and compares every result strobe against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module line_circle_span_clip_tb;
  import lcsc_pkg::*;

  localparam int STALL_LIMIT = 100000;

  typedef struct {
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] end_idx;
  } span_t;

  // scoreboard: own copy of the registers, span predictor, expected spans
  class span_board;
    logic [IDX_W-1:0]          count_reg;
    logic signed [COORD_W-1:0] step_x_reg;
    logic signed [COORD_W-1:0] step_y_reg;
    logic [RLIM_W-1:0]         rlim_reg;
    logic [RSQ_W-1:0]          rsq_reg;
    span_t                     expected_spans[$];
    int                        mismatches;

    function void reset_regs();
      count_reg = '0; step_x_reg = '0; step_y_reg = '0; rlim_reg = '0; rsq_reg = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SAMPLE_COUNT:   count_reg = data[IDX_W-1:0];
        REG_STEP_X:         step_x_reg = data[COORD_W-1:0];
        REG_STEP_Y:         step_y_reg = data[COORD_W-1:0];
        REG_RADIUS_LIMIT:   rlim_reg = data[RLIM_W-1:0];
        REG_RADIUS_SQUARED: rsq_reg = data[RSQ_W-1:0];
        default: ;
      endcase
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function bit on_disk(longint px, longint py);
      longint unsigned ux, uy;
      if (magnitude(px) >= 64'sd2147483648 || magnitude(py) >= 64'sd2147483648)
        return 1'b0;
      ux = magnitude(px);
      uy = magnitude(py);
      return (ux * ux + uy * uy) <= longint'(rsq_reg);
    endfunction

    function void note_request(logic signed [COORD_W-1:0] sx0, logic signed [COORD_W-1:0] sy0);
      longint x0, y0, sx, sy, m, xe, ye, lim, px, py, grad;
      longint unsigned ux, uy;
      longint first_i, end_i;
      bit hit;
      span_t s;
      x0 = sx0; y0 = sy0; sx = step_x_reg; sy = step_y_reg;
      lim = rlim_reg;
      m = (count_reg > MAX_SAMPLES) ? MAX_SAMPLES : count_reg;
      xe = x0 + m * sx;
      ye = y0 + m * sy;
      first_i = m; end_i = m; hit = 1'b0;
      if (magnitude(x0) <= lim && magnitude(xe) <= lim &&
          magnitude(y0) <= lim && magnitude(ye) <= lim) begin
        first_i = 0;
      end else if (sx != 0 || sy != 0) begin
        for (longint i = 0; i < m; i++) begin
          if (on_disk(x0 + i * sx, y0 + i * sy)) begin
            if (!hit) first_i = i;
            hit = 1'b1;
            end_i = i + 1;
          end
        end
        if (!hit) begin
          first_i = m;
        end else if (end_i == first_i + 1) begin
          // lone point: dropped when the row only grazes the circle there
          px = x0 + first_i * sx;
          py = y0 + first_i * sy;
          ux = magnitude(px);
          uy = magnitude(py);
          grad = sx * px + sy * py;
          if (ux * ux + uy * uy == longint'(rsq_reg) && grad == 0) begin
            first_i = m; end_i = m;
          end
        end
      end
      s.first_idx = first_i[IDX_W-1:0];
      s.end_idx = end_i[IDX_W-1:0];
      expected_spans.push_back(s);
    endfunction

    function void check_span(logic [IDX_W-1:0] got_first, logic [IDX_W-1:0] got_end);
      span_t s;
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: unexpected span first=%0d end=%0d", got_first, got_end);
        return;
      end
      s = expected_spans.pop_front();
      if (s.first_idx !== got_first || s.end_idx !== got_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: span mismatch expected first=%0d end=%0d, got first=%0d end=%0d",
                   s.first_idx, s.end_idx, got_first, got_end);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [COORD_W-1:0] in_start_x;
  logic signed [COORD_W-1:0] in_start_y;
  logic out_valid;
  logic [IDX_W-1:0] out_first_index;
  logic [IDX_W-1:0] out_end_index;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  span_board board;
  bit idle_on;       // random sender gaps enabled
  int stall_cycles;  // cycles with no request and no result

  line_circle_span_clip u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .out_valid(out_valid), .out_first_index(out_first_index),
    .out_end_index(out_end_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results cannot be held off, so every strobe is checked on the spot
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_span(out_first_index, out_end_index);
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one request through the start/busy handshake; start stays high afterwards
  task automatic send_row(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    if (idle_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start <= 1'b1;
    in_start_x <= x;
    in_start_y <= y;
    do @(posedge clk); while (busy);
    board.note_request(x, y);
  endtask

  // drain every expected span, then let the scanner settle before config
  task automatic drain();
    start <= 1'b0;
    while (board.expected_spans.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // all five registers written back to back while the block is idle
  task automatic load_regs(logic [IDX_W-1:0] m, logic signed [COORD_W-1:0] sx,
                           logic signed [COORD_W-1:0] sy, logic [RLIM_W-1:0] rl,
                           logic [RSQ_W-1:0] rs);
    logic [CFG_DATA_W-1:0] vals[5];
    vals[0] = CFG_DATA_W'(m); vals[1] = {30'd0, sx}; vals[2] = {30'd0, sy};
    vals[3] = CFG_DATA_W'(rl); vals[4] = rs;
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      board.write_reg(i[CFG_IDX_W-1:0], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // one random phase: a circle, a row direction, and rows mostly aimed across it
  task automatic random_phase(int n_rows, int m);
    longint r, smag, sx, sy, off_x, off_y;
    logic [RLIM_W-1:0] rl;
    logic [RSQ_W-1:0] rs;
    bit wild;
    wild = ($urandom_range(9) == 0);
    r = $urandom_range(1 << 10, 1 << 24);
    smag = (3 * r) / (m > 0 ? m : 1) + $urandom_range(0, r / (m > 0 ? m : 1) + 1);
    sx = ($urandom_range(1)) ? smag : -smag;
    sy = longint'($urandom_range(0, 2 * smag)) - smag;
    if ($urandom_range(5) == 0) sx = 0;
    if ($urandom_range(1)) begin off_x = sx; sx = sy; sy = off_x; end
    case ($urandom_range(3))
      0: rl = RLIM_W'(r);
      1: rl = RLIM_W'($urandom_range(0, r));
      2: rl = RLIM_W'($urandom);
      default: rl = 0;
    endcase
    rs = RSQ_W'(r * r + (($urandom_range(3) == 0) ? longint'($urandom_range(0, 1 << 20)) : 0));
    if (wild) begin
      // full-range registers so every bit toggles
      sx = $signed($urandom);
      sy = $signed($urandom);
      rs = RSQ_W'({$urandom, $urandom});
      rl = RLIM_W'($urandom);
    end
    load_regs(IDX_W'(m), COORD_W'(sx), COORD_W'(sy), rl, rs);
    for (int k = 0; k < n_rows; k++) begin
      if ($urandom_range(99) < 15) begin
        send_row($urandom, $urandom);
      end else begin
        off_x = longint'($urandom_range(0, 2 * r)) - r;
        off_y = longint'($urandom_range(0, 2 * r)) - r;
        send_row(COORD_W'(-(sx * m) / 2 + off_x), COORD_W'(-(sy * m) / 2 + off_y));
      end
    end
  endtask

  initial begin
    longint r;
    int m;
    board = new();
    board.reset_regs();
    rst_n = 1'b0;
    start = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero samples straight out of reset
    send_row(32'sd0, 32'sd0);
    send_row(32'h8000_0000, 32'h7fff_ffff);

    // grazing row: y = r, sample 3 sits on the top of the circle
    r = 5 << 16;
    load_regs(13'd8, 32'sd65536, 32'sd0, RLIM_W'(r - 1), RSQ_W'(r * r));
    send_row(-(3 << 16), COORD_W'(r));
    send_row(-(3 << 16) + 32'sh8000, COORD_W'(r));  // touches between samples
    send_row(-(3 << 16), 32'sd0);        // crosses the middle
    send_row(-(3 << 16), COORD_W'(-r));
    send_row(32'h8000_0000, 32'h7fff_ffff);
    send_row(32'h7fff_ffff, 32'h8000_0000);
    send_row(32'sd100 << 16, 32'sd0);     // span off the row

    // degenerate steps
    load_regs(13'd16, 32'sd0, 32'sd0, 31'd0, RSQ_W'(r * r));
    send_row(32'sd1, 32'sd1);
    send_row(32'sd0, 32'sd0);

    // oversized count clamps, quick test passes for the first row with widest radius
    load_regs(13'h1fff, 32'sd1, -32'sd1, 31'h7fff_ffff, {RSQ_W{1'b1}});
    send_row(32'sd0, 32'sd0);
    send_row(32'h8000_0000, 32'h7fff_ffff);

    // full-size row that has to be scanned
    load_regs(13'd4096, 32'sd256, 32'sd128, 31'd0, RSQ_W'(longint'(1) << 48));
    send_row(-(32'sd256 * 2048), -(32'sd128 * 2048));
    send_row(32'sd0, 32'sd0);
    send_row(32'h8000_0000, 32'h8000_0000);

    // random phases, mostly short rows; phases 4 to 7 run without gaps
    for (int ph = 0; ph < 30; ph++) begin
      idle_on = !(ph >= 4 && ph <= 7);
      if (ph % 10 == 9) begin
        m = ($urandom_range(1)) ? 4096 : $urandom_range(4097, 8191);
        random_phase(3, m);
      end else begin
        m = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 48);
        random_phase(48, m);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/lcsc_pkg.sv
sv/lcsc_front.sv
sv/lcsc_fifo.sv
sv/lcsc_back.sv
sv/line_circle_span_clip.sv
sv/lcsc_checker.sv
tb/line_circle_span_clip_tb.sv
